// File: sv/vfcm_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the voxel face cull mesher
package vfcm_pkg;

	localparam int CHUNK_EDGE_DEF = 16;
	localparam int ID_BITS_DEF    = 8;

	localparam logic [2:0] CMD_WR_VOXEL  = 3'd0;
	localparam logic [2:0] CMD_WR_BORDER = 3'd1;
	localparam logic [2:0] CMD_WR_TRANS  = 3'd2;
	localparam logic [2:0] CMD_SET_INDEX = 3'd3;
	localparam logic [2:0] CMD_READ      = 3'd4;
	localparam logic [2:0] CMD_QUERY     = 3'd5;

	localparam logic [2:0] DIR_PZ = 3'd0;
	localparam logic [2:0] DIR_NZ = 3'd1;
	localparam logic [2:0] DIR_NX = 3'd2;
	localparam logic [2:0] DIR_PX = 3'd3;
	localparam logic [2:0] DIR_PY = 3'd4;
	localparam logic [2:0] DIR_NY = 3'd5;
	localparam logic [2:0] DIR_LAST = DIR_NY;

	localparam logic [1:0] REG_FILL    = 2'd0;
	localparam logic [1:0] REG_YOFF    = 2'd1;
	localparam logic [1:0] REG_PRESENT = 2'd2;

	localparam logic KIND_FACE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [31:0] FACE_INDEX_STEP = 32'd4;

	localparam logic signed [13:0] FACE_Y_MAX = 14'sd4095;
	localparam logic signed [13:0] FACE_Y_MIN = -14'sd4096;

	typedef struct packed {
		logic [7:0]         fill;
		logic signed [12:0] yoff;
		logic [5:0]         present;
	} cfg_t;

endpackage

// File: sv/vfcm_if.sv
`timescale 1ns / 1ps
// channel interfaces: command word, result word, register write word
interface vfcm_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [3:0]  cell_x;
	logic [3:0]  cell_y;
	logic [3:0]  cell_z;
	logic [2:0]  side;
	logic [31:0] value;
	modport source (output valid, cmd, cell_x, cell_y, cell_z, side, value, input ready);
	modport sink (input valid, cmd, cell_x, cell_y, cell_z, side, value, output ready);
endinterface

interface vfcm_result_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [3:0]         face_x;
	logic signed [12:0] face_y;
	logic [3:0]         face_z;
	logic [2:0]         direction;
	logic [31:0]        first_index;
	logic [7:0]         block_value;
	logic               last;
	modport source (output valid, kind, face_x, face_y, face_z, direction, first_index,
		block_value, last, input ready);
	modport sink (input valid, kind, face_x, face_y, face_z, direction, first_index,
		block_value, last, output ready);
endinterface

interface vfcm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/vfcm_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram with registered read
module vfcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: sv/vfcm_cfg.sv
`timescale 1ns / 1ps
// configuration register file
module vfcm_cfg (
	input  logic            clk,
	input  logic            arst_n,
	vfcm_cfg_if.sink        cfg,
	output vfcm_pkg::cfg_t  regs
);
	vfcm_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				vfcm_pkg::REG_FILL: begin
					regs_q.fill <= cfg.data[7:0];
				end
				vfcm_pkg::REG_YOFF: begin
					regs_q.yoff <= cfg.data[12:0];
				end
				vfcm_pkg::REG_PRESENT: begin
					regs_q.present <= cfg.data[5:0];
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// File: sv/voxel_face_cull_mesher_core.sv
`timescale 1ns / 1ps
// voxel face cull mesher top level: command sequencer around chunk, border and id rams
//
// item channel takes one command word: write voxel, write border cell, write
// transparency bit, set index counter, read voxel or query voxel. result channel
// gives read words (kind 1) and one face word per visible face of a query, in the
// order +z, -z, -x, +x, +y, -y, with last on the final word of the command.
// cfg channel writes fill block, y offset and neighbor present; always ready.
// writes and set index are done in the idle state. a read goes through a wait state
// to its result word. a query reads the center voxel, then per direction reads the
// chunk or border ram and the transparency ram and decides (S_NB, S_TR, S_DEC), then
// gives one face word per visible face; a query whose faces are all hidden gives
// none. a query on an empty voxel ends after the center read, with no word.
// after reset a clearing pass over all chunk ram addresses and transparency ids
// zeroes the written marks and transparency bits; item.ready is low during it.
// a full result register holds its word while the receiver stalls; the sequencer
// waits for it to drain and then goes on.
module voxel_face_cull_mesher_core #(
	parameter int CHUNK_EDGE = vfcm_pkg::CHUNK_EDGE_DEF,
	parameter int ID_BITS    = vfcm_pkg::ID_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	vfcm_item_if.sink     item,
	vfcm_result_if.source result,
	vfcm_cfg_if.sink      cfg
);
	localparam int CB     = $clog2(CHUNK_EDGE);
	localparam int VAW    = 3 * CB;
	localparam int BAW    = 3 + 2 * CB;
	localparam int CLR_W  = (VAW > ID_BITS) ? VAW : ID_BITS;
	localparam int CX_W   = (CB > 4) ? CB : 4;
	localparam int FILL_W = (ID_BITS > 8) ? ID_BITS : 8;
	localparam logic [CB-1:0] EDGE_MAX = CB'(CHUNK_EDGE - 1);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_RD_WAIT = 4'd2;
	localparam logic [3:0] S_RD_EMIT = 4'd3;
	localparam logic [3:0] S_Q_CTR   = 4'd4;
	localparam logic [3:0] S_NB      = 4'd5;
	localparam logic [3:0] S_TR      = 4'd6;
	localparam logic [3:0] S_DEC     = 4'd7;
	localparam logic [3:0] S_EMIT    = 4'd8;

	vfcm_pkg::cfg_t regs;

	logic [3:0]         state_q;
	logic [CLR_W-1:0]   clr_q;
	logic [3:0]         x4_q, y4_q, z4_q;
	logic [CB-1:0]      cx_q, cy_q, cz_q;
	logic               inside_q;
	logic [ID_BITS-1:0] id_q, nb_q;
	logic               edge_q;
	logic [2:0]         dir_q;
	logic [5:0]         vis_q;
	logic [31:0]        idx_q;

	logic               rv_q, r_kind_q, r_last_q;
	logic [3:0]         r_x_q, r_z_q;
	logic signed [12:0] r_y_q;
	logic [2:0]         r_dir_q;
	logic [31:0]        r_first_q;
	logic [7:0]         r_bv_q;

	logic               accept, inside_in, slot;
	logic [CX_W-1:0]    ix_e, iy_e, iz_e;
	logic [CB-1:0]      ix, iy, iz;
	logic [FILL_W-1:0]  fill_e;
	logic [ID_BITS-1:0] fill_id, vox_id, nb_comb;
	logic [FILL_W-1:0]  id_e;

	logic               vox_we;
	logic [VAW-1:0]     vox_waddr, vox_raddr;
	logic [ID_BITS:0]   vox_wdata, vox_rdata;
	logic               bor_we;
	logic [BAW-1:0]     bor_waddr, bor_raddr;
	logic [ID_BITS-1:0] bor_wdata, bor_rdata;
	logic               tr_we;
	logic [ID_BITS-1:0] tr_waddr, tr_raddr;
	logic               tr_wdata, tr_rdata;

	logic [CB-1:0]      nx, ny, nz;
	logic               nb_edge;
	logic [2:0]         emit_dir;
	logic [5:0]         vis_rest;
	logic signed [13:0] y_sum;
	logic signed [12:0] y_sat;
	logic               load_face, load_read;

	vfcm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	vfcm_ram #(.WIDTH(ID_BITS + 1), .DEPTH(1 << VAW)) u_vox_ram (
		.clk(clk), .we(vox_we), .waddr(vox_waddr), .wdata(vox_wdata),
		.raddr(vox_raddr), .rdata(vox_rdata)
	);

	vfcm_ram #(.WIDTH(ID_BITS), .DEPTH(1 << BAW)) u_bor_ram (
		.clk(clk), .we(bor_we), .waddr(bor_waddr), .wdata(bor_wdata),
		.raddr(bor_raddr), .rdata(bor_rdata)
	);

	vfcm_ram #(.WIDTH(1), .DEPTH(1 << ID_BITS)) u_tr_ram (
		.clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
		.raddr(tr_raddr), .rdata(tr_rdata)
	);

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign slot       = !rv_q || result.ready;

	assign ix_e = CX_W'(item.cell_x);
	assign iy_e = CX_W'(item.cell_y);
	assign iz_e = CX_W'(item.cell_z);
	assign ix   = ix_e[CB-1:0];
	assign iy   = iy_e[CB-1:0];
	assign iz   = iz_e[CB-1:0];
	assign inside_in = (7'(item.cell_x) < 7'(CHUNK_EDGE)) && (7'(item.cell_y) < 7'(CHUNK_EDGE))
		&& (7'(item.cell_z) < 7'(CHUNK_EDGE));

	assign fill_e  = FILL_W'(regs.fill);
	assign fill_id = fill_e[ID_BITS-1:0];
	assign vox_id  = vox_rdata[ID_BITS] ? vox_rdata[ID_BITS-1:0] : fill_id;
	assign id_e    = FILL_W'(id_q);

	// neighbor of the center cell in the current direction
	always_comb begin
		nx = cx_q;
		ny = cy_q;
		nz = cz_q;
		nb_edge = 1'b1;
		case (dir_q)
			vfcm_pkg::DIR_PZ: begin
				nz = cz_q + CB'(1);
				nb_edge = (cz_q == EDGE_MAX);
			end
			vfcm_pkg::DIR_NZ: begin
				nz = cz_q - CB'(1);
				nb_edge = (cz_q == '0);
			end
			vfcm_pkg::DIR_NX: begin
				nx = cx_q - CB'(1);
				nb_edge = (cx_q == '0);
			end
			vfcm_pkg::DIR_PX: begin
				nx = cx_q + CB'(1);
				nb_edge = (cx_q == EDGE_MAX);
			end
			vfcm_pkg::DIR_PY: begin
				ny = cy_q + CB'(1);
				nb_edge = (cy_q == EDGE_MAX);
			end
			vfcm_pkg::DIR_NY: begin
				ny = cy_q - CB'(1);
				nb_edge = (cy_q == '0);
			end
			default: begin
			end
		endcase
	end

	// ram ports
	always_comb begin
		vox_we    = 1'b0;
		vox_waddr = {iz, iy, ix};
		vox_wdata = {1'b1, item.value[ID_BITS-1:0]};
		bor_we    = 1'b0;
		bor_wdata = item.value[ID_BITS-1:0];
		tr_we     = 1'b0;
		tr_waddr  = item.value[ID_BITS-1:0];
		tr_wdata  = item.value[ID_BITS];
		if (item.side < 3'd2) begin
			bor_waddr = {item.side, iy, ix};
		end else if (item.side < 3'd4) begin
			bor_waddr = {item.side, iz, iy};
		end else begin
			bor_waddr = {item.side, iz, ix};
		end
		if (state_q == S_CLEAR) begin
			vox_we    = 1'b1;
			vox_waddr = clr_q[VAW-1:0];
			vox_wdata = '0;
			tr_we     = 1'b1;
			tr_waddr  = clr_q[ID_BITS-1:0];
			tr_wdata  = 1'b0;
		end else if (accept) begin
			vox_we = (item.cmd == vfcm_pkg::CMD_WR_VOXEL) && inside_in;
			bor_we = (item.cmd == vfcm_pkg::CMD_WR_BORDER) && inside_in
				&& (item.side <= vfcm_pkg::DIR_LAST);
			tr_we  = (item.cmd == vfcm_pkg::CMD_WR_TRANS);
		end
		vox_raddr = (state_q == S_NB) ? {nz, ny, nx} : {iz, iy, ix};
		if (dir_q < 3'd2) begin
			bor_raddr = {dir_q, cy_q, cx_q};
		end else if (dir_q < 3'd4) begin
			bor_raddr = {dir_q, cz_q, cy_q};
		end else begin
			bor_raddr = {dir_q, cz_q, cx_q};
		end
		nb_comb  = edge_q ? (regs.present[dir_q] ? bor_rdata : '0) : vox_id;
		tr_raddr = nb_comb;
	end

	// face emission
	always_comb begin
		emit_dir = vfcm_pkg::DIR_PZ;
		for (int i = 5; i >= 0; i--) begin
			if (vis_q[i]) begin
				emit_dir = 3'(i);
			end
		end
		vis_rest  = vis_q & ~(6'b1 << emit_dir);
		y_sum     = 14'(regs.yoff) + 14'(signed'({10'b0, y4_q}));
		if (y_sum > vfcm_pkg::FACE_Y_MAX) begin
			y_sat = 13'(vfcm_pkg::FACE_Y_MAX);
		end else if (y_sum < vfcm_pkg::FACE_Y_MIN) begin
			y_sat = 13'(vfcm_pkg::FACE_Y_MIN);
		end else begin
			y_sat = y_sum[12:0];
		end
		load_face = (state_q == S_EMIT) && (vis_q != '0) && slot;
		load_read = (state_q == S_RD_EMIT) && slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
			dir_q   <= '0;
			vis_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (load_face || load_read) begin
				rv_q <= 1'b1;
			end else if (result.ready) begin
				rv_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (item.cmd)
							vfcm_pkg::CMD_SET_INDEX: begin
								idx_q <= item.value;
							end
							vfcm_pkg::CMD_READ: begin
								state_q <= S_RD_WAIT;
							end
							vfcm_pkg::CMD_QUERY: begin
								if (inside_in) begin
									state_q <= S_Q_CTR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					if (slot) begin
						state_q <= S_IDLE;
					end
				end
				S_Q_CTR: begin
					dir_q <= vfcm_pkg::DIR_PZ;
					vis_q <= '0;
					state_q <= (vox_id == '0) ? S_IDLE : S_NB;
				end
				S_NB: begin
					state_q <= S_TR;
				end
				S_TR: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					vis_q[dir_q] <= (nb_q == '0) || tr_rdata;
					if (dir_q == vfcm_pkg::DIR_LAST) begin
						state_q <= S_EMIT;
					end else begin
						dir_q   <= dir_q + 3'd1;
						state_q <= S_NB;
					end
				end
				S_EMIT: begin
					if (vis_q == '0) begin
						state_q <= S_IDLE;
					end else if (slot) begin
						vis_q <= vis_rest;
						idx_q <= idx_q + vfcm_pkg::FACE_INDEX_STEP;
						if (vis_rest == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x4_q     <= item.cell_x;
			y4_q     <= item.cell_y;
			z4_q     <= item.cell_z;
			cx_q     <= ix;
			cy_q     <= iy;
			cz_q     <= iz;
			inside_q <= inside_in;
		end
		if (state_q == S_RD_WAIT || state_q == S_Q_CTR) begin
			id_q <= vox_id;
		end
		if (state_q == S_NB) begin
			edge_q <= nb_edge;
		end
		if (state_q == S_TR) begin
			nb_q <= nb_comb;
		end
		if (load_read) begin
			r_kind_q  <= vfcm_pkg::KIND_READ;
			r_x_q     <= '0;
			r_y_q     <= '0;
			r_z_q     <= '0;
			r_dir_q   <= '0;
			r_first_q <= '0;
			r_bv_q    <= inside_q ? id_e[7:0] : 8'd0;
			r_last_q  <= 1'b1;
		end else if (load_face) begin
			r_kind_q  <= vfcm_pkg::KIND_FACE;
			r_x_q     <= x4_q;
			r_y_q     <= y_sat;
			r_z_q     <= z4_q;
			r_dir_q   <= emit_dir;
			r_first_q <= idx_q;
			r_bv_q    <= id_e[7:0];
			r_last_q  <= (vis_rest == '0);
		end
	end

	assign result.valid       = rv_q;
	assign result.kind        = r_kind_q;
	assign result.face_x      = r_x_q;
	assign result.face_y      = r_y_q;
	assign result.face_z      = r_z_q;
	assign result.direction   = r_dir_q;
	assign result.first_index = r_first_q;
	assign result.block_value = r_bv_q;
	assign result.last        = r_last_q;

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !item.ready)
		else $error("item taken during clearing pass");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		load_face |=> idx_q == $past(idx_q) + vfcm_pkg::FACE_INDEX_STEP)
		else $error("index counter did not advance by one face");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load_face && vis_rest == '0 |=> state_q == S_IDLE && rv_q && r_last_q)
		else $error("final face not marked last");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NB |-> dir_q <= vfcm_pkg::DIR_LAST)
		else $error("direction out of range");

endmodule
